>>> rtl/lzbsd_pkg.sv
// shared types, constants and command format for the lz byte stream decompressor
// used by every module of the block; depends on nothing
package lzbsd_pkg;

   // history window and output packing
   localparam int HIST_DEPTH  = 512;
   localparam int HIST_AW     = $clog2(HIST_DEPTH);
   localparam int OUT_LANES   = 4;
   localparam int LANES_USED  = (OUT_LANES > 4) ? 4 : ((OUT_LANES < 1) ? 1 : OUT_LANES);
   localparam int LANE_W      = (LANES_USED > 1) ? $clog2(LANES_USED) : 1;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // control byte fields and count bases
   localparam logic [4:0]  NUM_MASK      = 5'h1F;
   localparam logic [15:0] LIT_BASE      = 16'd31;
   localparam logic [15:0] SHORT_BASE    = 16'd35;
   localparam logic [15:0] LONG_BASE     = 16'd32;
   localparam logic [15:0] LONG_SCALE_SH = 16'd2;   // times 4
   localparam logic [15:0] FILL_HI_SH    = 16'd5;   // times 32
   localparam logic [15:0] LONG_EXTRA    = 16'd2;

   // control codes in bits 7..6
   localparam logic [1:0] CODE_LIT   = 2'd0;
   localparam logic [1:0] CODE_SHORT = 2'd1;
   localparam logic [1:0] CODE_LONG  = 2'd2;
   localparam logic [1:0] CODE_FILL  = 2'd3;

   // result kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_FILL = 1'b1;

   typedef enum logic [2:0] {
      PH_CTRL,
      PH_LIT,
      PH_SHORT,
      PH_LONG,
      PH_FHI,
      PH_FSKIP,
      PH_FVAL
   } phase_type;

   typedef enum logic [1:0] {
      OP_LIT,
      OP_COPY,
      OP_FILL
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LIT,
      BK_FILL,
      BK_SWEEP,
      BK_COPY_RD,
      BK_COPY_WR
   } back_state_type;

   // one unit of work for the back part
   typedef struct packed {
      op_type      op;
      logic [7:0]  value;      // literal byte or fill value
      logic [8:0]  distance;   // copy distance
      logic [15:0] count;      // clamped byte count
      logic [23:0] base;       // bytes produced before this command
      logic        done;       // command brings produced to out_length
   } cmd_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } q_status_type;

endpackage

>>> rtl/lz_byte_stream_decompressor_top.sv
// top level of the lz byte stream decompressor: length register, front, queue, back
// depends on lzbsd_pkg, lzbsd_front, lzbsd_queue, lzbsd_back
//
// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  tdata: in_byte; tuser: start_req
// rsp       out        rsp_tvalid/rsp_tready  tdata: data, length, done_res; tuser: kind;
//                                             tlast: last_of_run
// csr       in         csr_wr_en              csr_wr_data: out_length
//
// front: one request per cycle while the queue has room; header bytes cost that cycle only
// back: a literal passes BK_IDLE, then BK_LIT; a copy, after BK_IDLE, does per byte a history read, then a write
// back: a fill gives its result, then sweeps min(length, 512) bytes into history, one history write per cycle
// reset is synchronous and clears control state; history is not swept after reset or start
// bytes of an earlier stream are never read back, such distances read as zero
// a stalled result holds the back only; the front takes requests until the queue fills
module lz_byte_stream_decompressor_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] start_req
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [31:0] data, [47:32] length, [48] done_res, rest zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,   // last_of_run
   // configuration
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data  // out_length
);
   import lzbsd_pkg::*;

   logic [23:0]  out_length_ff, out_length_in;
   logic         accept;
   logic         push;
   cmd_type      push_cmd;
   cmd_type      head;
   q_status_type q_status;
   logic         pop;
   logic [31:0]  rsp_data;
   logic [15:0]  rsp_len;
   logic         rsp_done;

   // output length register
   assign out_length_in = csr_wr_en ? csr_wr_data : out_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_length_ff <= '0;
      end else begin
         out_length_ff <= out_length_in;
      end
   end

   assign req_tready = q_status.not_full;
   assign accept     = req_tvalid && req_tready;

   lzbsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_tdata),
      .start_req  (req_tuser),
      .out_length (out_length_ff),
      .push       (push),
      .cmd        (push_cmd)
   );

   lzbsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   lzbsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (q_status.not_empty),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_data   (rsp_data),
      .rsp_len    (rsp_len),
      .rsp_last   (rsp_tlast),
      .rsp_done   (rsp_done)
   );

   // result packing
   assign rsp_tdata = {7'd0, rsp_done, rsp_len, rsp_data};

endmodule

>>> rtl/lzbsd_front.sv
// front part: parses control bytes, clamps counts and issues commands
// depends on lzbsd_pkg
module lzbsd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic                 start_req,
   input  logic [23:0]          out_length,
   output logic                 push,
   output lzbsd_pkg::cmd_type   cmd
);
   import lzbsd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [4:0]  pending_ff, pending_in;
   logic [4:0]  held_num_ff, held_num_in;
   logic        held_flag_ff, held_flag_in;
   logic [7:0]  fill_high_ff, fill_high_in;
   logic [23:0] produced_ff, produced_in;

   phase_type   eff_phase;
   logic [4:0]  eff_pending;
   logic [23:0] eff_prod;
   logic [23:0] rem;
   logic        active;
   logic [15:0] raw_cnt;
   logic        clip;
   logic [15:0] base_len;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CTRL;
         pending_ff   <= '0;
         held_num_ff  <= '0;
         held_flag_ff <= 1'b0;
         fill_high_ff <= '0;
         produced_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         pending_ff   <= pending_in;
         held_num_ff  <= held_num_in;
         held_flag_ff <= held_flag_in;
         fill_high_ff <= fill_high_in;
         produced_ff  <= produced_in;
      end
   end

   // start of stream clears position and parse state before the byte is used
   assign eff_phase   = start_req ? PH_CTRL : phase_ff;
   assign eff_pending = start_req ? 5'd0 : pending_ff;
   assign eff_prod    = start_req ? 24'd0 : produced_ff;
   assign rem         = out_length - eff_prod;
   assign active      = eff_prod < out_length;
   assign base_len    = LONG_BASE - 16'(held_num_ff);

   // raw byte count of the command this byte completes
   always_comb begin
      unique case (eff_phase)
         PH_SHORT: raw_cnt = SHORT_BASE - 16'(held_num_ff);
         PH_LONG:  raw_cnt = (base_len << LONG_SCALE_SH) + (held_flag_ff ? LONG_EXTRA : 16'd0);
         PH_FVAL:  raw_cnt = (base_len + (16'(fill_high_ff) << FILL_HI_SH)) << LONG_SCALE_SH;
         default:  raw_cnt = 16'd1;
      endcase
   end

   // clamp to the bytes left before out_length
   assign clip = {8'd0, raw_cnt} >= rem;

   // next parse state and command
   always_comb begin
      phase_in     = phase_ff;
      pending_in   = pending_ff;
      held_num_in  = held_num_ff;
      held_flag_in = held_flag_ff;
      fill_high_in = fill_high_ff;
      produced_in  = produced_ff;
      push         = 1'b0;
      cmd.op       = OP_LIT;
      cmd.value    = in_byte;
      cmd.distance = '0;
      cmd.count    = clip ? rem[15:0] : raw_cnt;
      cmd.base     = eff_prod;
      cmd.done     = clip;
      if (accept) begin
         phase_in    = eff_phase;
         pending_in  = eff_pending;
         produced_in = eff_prod;
         if (active) begin
            unique case (eff_phase)
               PH_CTRL: begin
                  held_flag_in = in_byte[5];
                  held_num_in  = in_byte[4:0] & NUM_MASK;
                  unique case (in_byte[7:6])
                     CODE_LIT: begin
                        pending_in = 5'(LIT_BASE) - (in_byte[4:0] & NUM_MASK);
                        phase_in   = (pending_in != 5'd0) ? PH_LIT : PH_CTRL;
                     end
                     CODE_SHORT: phase_in = PH_SHORT;
                     CODE_LONG:  phase_in = PH_LONG;
                     CODE_FILL:  phase_in = in_byte[5] ? PH_CTRL : PH_FHI;
                     default:    phase_in = PH_CTRL;
                  endcase
               end
               PH_LIT: begin
                  push        = 1'b1;
                  cmd.op      = OP_LIT;
                  pending_in  = eff_pending - 5'd1;
                  phase_in    = (eff_pending == 5'd1) ? PH_CTRL : PH_LIT;
                  produced_in = clip ? out_length : eff_prod + 24'(raw_cnt);
               end
               PH_SHORT: begin
                  push         = 1'b1;
                  cmd.op       = OP_COPY;
                  cmd.distance = {held_flag_ff, in_byte};
                  phase_in     = PH_CTRL;
                  produced_in  = clip ? out_length : eff_prod + 24'(raw_cnt);
               end
               PH_LONG: begin
                  push         = 1'b1;
                  cmd.op       = OP_COPY;
                  cmd.distance = {in_byte, 1'b0};
                  phase_in     = PH_CTRL;
                  produced_in  = clip ? out_length : eff_prod + 24'(raw_cnt);
               end
               PH_FHI: begin
                  fill_high_in = in_byte;
                  phase_in     = PH_FSKIP;
               end
               PH_FSKIP: phase_in = PH_FVAL;
               PH_FVAL: begin
                  push        = 1'b1;
                  cmd.op      = OP_FILL;
                  phase_in    = PH_CTRL;
                  produced_in = clip ? out_length : eff_prod + 24'(raw_cnt);
               end
               default: phase_in = PH_CTRL;
            endcase
         end
      end
   end

endmodule

>>> rtl/lzbsd_queue.sv
// short command queue between front and back parts
// depends on lzbsd_pkg
module lzbsd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lzbsd_pkg::cmd_type      push_cmd,
   input  logic                    pop,
   output lzbsd_pkg::cmd_type      head,
   output lzbsd_pkg::q_status_type status
);
   import lzbsd_pkg::*;

   cmd_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   // pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CW'(push) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head             = entries_ff[rd_ptr_ff];
   assign status.not_empty = count_ff != '0;
   assign status.not_full  = count_ff != QUEUE_CW'(QUEUE_DEPTH);

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != QUEUE_CW'(QUEUE_DEPTH) || pop))
      else $error("command pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("command popped from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("queue fill level out of range");
`endif

endmodule

>>> rtl/lzbsd_back.sv
// back part: history memory, copy and fill engine, result register
// depends on lzbsd_pkg
module lzbsd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  lzbsd_pkg::cmd_type    head,
   input  logic                  head_valid,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_kind,
   output logic [31:0]           rsp_data,
   output logic [15:0]           rsp_len,
   output logic                  rsp_last,
   output logic                  rsp_done
);
   import lzbsd_pkg::*;

   logic [7:0] history_mem [HIST_DEPTH];

   back_state_type    state_ff, state_in;
   logic [7:0]        val_ff, val_in;
   logic [8:0]        dist_ff, dist_in;
   logic [15:0]       cnt_ff, cnt_in;
   logic [23:0]       pos_ff, pos_in;
   logic              done_ff, done_in;
   logic [31:0]       word_ff, word_in;
   logic [LANE_W-1:0] lane_ff, lane_in;
   logic              rd_zero_ff, rd_zero_in;
   logic [7:0]        rd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic [15:0]       rsp_len_ff, rsp_len_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_done_ff, rsp_done_in;

   logic              out_free;
   logic              rd_en;
   logic [HIST_AW-1:0] rd_addr;
   logic              wr_en;
   logic [HIST_AW-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [7:0]        copy_byte;
   logic              last_byte;
   logic              emit_need;
   logic [31:0]       word_new;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload registers
   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      dist_ff     <= dist_in;
      cnt_ff      <= cnt_in;
      pos_ff      <= pos_in;
      done_ff     <= done_in;
      word_ff     <= word_in;
      lane_ff     <= lane_in;
      rd_zero_ff  <= rd_zero_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   // history memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         history_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= history_mem[rd_addr];
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rd_addr   = pos_ff[HIST_AW-1:0] - HIST_AW'(dist_ff);
   assign wr_addr   = pos_ff[HIST_AW-1:0];
   assign copy_byte = rd_zero_ff ? 8'd0 : rd_data_ff;
   assign last_byte = cnt_ff == 16'd1;
   assign emit_need = last_byte || (lane_ff == LANE_W'(LANES_USED - 1));

   // copy byte placed in its lane
   always_comb begin
      word_new = word_ff;
      word_new[lane_ff * 8 +: 8] = copy_byte;
   end

   // sequencer: next state, memory strobes, result loading
   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      dist_in      = dist_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      done_in      = done_ff;
      word_in      = word_ff;
      lane_in      = lane_ff;
      rd_zero_in   = rd_zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_data      = val_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               pop     = 1'b1;
               val_in  = head.value;
               dist_in = head.distance;
               cnt_in  = head.count;
               pos_in  = head.base;
               done_in = head.done;
               word_in = '0;
               lane_in = '0;
               unique case (head.op)
                  OP_LIT:  state_in = BK_LIT;
                  OP_COPY: state_in = BK_COPY_RD;
                  OP_FILL: state_in = BK_FILL;
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_LIT: begin
            if (out_free) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DATA;
               rsp_data_in  = {24'd0, val_ff};
               rsp_len_in   = 16'd1;
               rsp_last_in  = 1'b1;
               rsp_done_in  = done_ff;
               state_in     = BK_IDLE;
            end
         end
         BK_FILL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FILL;
               rsp_data_in  = {24'd0, val_ff};
               rsp_len_in   = cnt_ff;
               rsp_last_in  = 1'b1;
               rsp_done_in  = done_ff;
               // only the newest window of fill bytes can ever be read back
               cnt_in       = (cnt_ff >= 16'(HIST_DEPTH)) ? 16'(HIST_DEPTH) : cnt_ff;
               state_in     = BK_SWEEP;
            end
         end
         BK_SWEEP: begin
            wr_en  = 1'b1;
            pos_in = pos_ff + 24'd1;
            cnt_in = cnt_ff - 16'd1;
            if (last_byte) begin
               state_in = BK_IDLE;
            end
         end
         BK_COPY_RD: begin
            // distance zero or before the stream start reads zero
            rd_en      = 1'b1;
            rd_zero_in = (dist_ff == 9'd0) || ({15'd0, dist_ff} > pos_ff);
            state_in   = BK_COPY_WR;
         end
         BK_COPY_WR: begin
            if (!emit_need || out_free) begin
               wr_en   = 1'b1;
               wr_data = copy_byte;
               pos_in  = pos_ff + 24'd1;
               cnt_in  = cnt_ff - 16'd1;
               if (emit_need) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_DATA;
                  rsp_data_in  = word_new;
                  rsp_len_in   = 16'(lane_ff) + 16'd1;
                  rsp_last_in  = last_byte;
                  rsp_done_in  = last_byte && done_ff;
                  word_in      = '0;
                  lane_in      = '0;
               end else begin
                  word_in = word_new;
                  lane_in = lane_ff + 1'b1;
               end
               state_in = last_byte ? BK_IDLE : BK_COPY_RD;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_len   = rsp_len_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_done  = rsp_done_ff;

`ifndef SYNTHESIS
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_COPY_WR) |->
         ($past(state_ff) == BK_COPY_RD || $past(state_ff) == BK_COPY_WR))
      else $error("copy write without a preceding history read");
   a_data_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_DATA) |->
         (rsp_len_ff != 16'd0 && rsp_len_ff <= 16'(LANES_USED)))
      else $error("data result with bad byte count");
   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> rsp_last_ff)
      else $error("done flagged before the last result of a request");
`endif

endmodule

>>> bench/testbench.sv
// self-checking bench for lz_byte_stream_decompressor_top: streams compressed bytes in,
// predicts every output word from its own decoder model and checks the result stream
// depends on lzbsd_pkg and the rtl of the decompressor top level
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lzbsd_pkg::*;

   localparam int RESET_CYCLES    = 7;
   localparam int SETTLE_CYCLES   = 600;    // longest fill sweep plus margin
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 20000;

   // one expected output word
   typedef struct {
      logic        kind;
      logic [31:0] data;
      logic [15:0] length;
      logic        last;
      logic        done;
   } out_word_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic [23:0] csr_wr_data = 24'h000000;

   // decoder model state
   logic [7:0]  hist [HIST_DEPTH];
   logic [8:0]  wr_pos;
   logic [23:0] produced;
   logic [23:0] out_len;
   phase_type   phase;
   logic [5:0]  pending;
   logic [4:0]  held_num;
   logic        held_flag;
   logic [7:0]  fill_high;

   out_word_type expected_words [$];
   out_word_type check_head;
   int unsigned taken_items = 0;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned stall_left = 0;
   int unsigned hold_off_req = 0;
   int unsigned hold_off_seen = 0;
   bit          gaps_on = 1'b1;

   lz_byte_stream_decompressor_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- decoder model

   function automatic void push_hist(input logic [7:0] b);
      hist[wr_pos] = b;
      wr_pos = wr_pos + 1'b1;
      produced = produced + 1'b1;
   endfunction

   function automatic int unsigned clamp_count(input int unsigned count);
      logic [23:0] rem;
      rem = out_len - produced;
      return (count < rem) ? count : rem;
   endfunction

   function automatic void emit_word(input logic kind, input logic [31:0] data,
                                     input int unsigned len, input logic last);
      out_word_type w;
      w.kind   = kind;
      w.data   = data;
      w.length = 16'(len);
      w.last   = last;
      w.done   = (produced == out_len);
      expected_words.insert(expected_words.size(), w);
   endfunction

   // byte-wise copy through the history, packed into output words
   function automatic void copy_from_hist(input int unsigned distance, input int unsigned want);
      int unsigned count;
      int unsigned lanes;
      int unsigned i;
      logic [31:0] word;
      logic [7:0]  cb;
      logic [8:0]  rd_idx;
      count = clamp_count(want);
      lanes = 0;
      word  = '0;
      for (i = 0; i < count; i++) begin
         cb = 8'h00;
         if (distance != 0 && distance <= produced && distance < HIST_DEPTH) begin
            rd_idx = wr_pos - distance[8:0];
            cb = hist[rd_idx];
         end
         push_hist(cb);
         word |= 32'(cb) << (8 * lanes);
         lanes++;
         if (lanes == LANES_USED || i + 1 == count) begin
            emit_word(KIND_DATA, word, lanes, i + 1 == count);
            word  = '0;
            lanes = 0;
         end
      end
   endfunction

   // returns 1 when the byte is taken, 0 when the block ignores it
   function automatic bit decode_byte(input logic [7:0] b, input logic st);
      int unsigned count;
      int unsigned i;
      if (st) begin
         hist     = '{default: 8'h00};
         wr_pos   = '0;
         produced = '0;
         phase    = PH_CTRL;
         pending  = '0;
      end
      if (produced >= out_len)
         return 1'b0;
      unique case (phase)
         PH_CTRL: begin
            held_flag = b[5];
            held_num  = b[4:0];
            if (b[7:6] == CODE_LIT) begin
               pending = 6'(LIT_BASE - 16'(held_num));
               phase   = (pending != 0) ? PH_LIT : PH_CTRL;
            end else if (b[7:6] == CODE_SHORT) begin
               phase = PH_SHORT;
            end else if (b[7:6] == CODE_LONG) begin
               phase = PH_LONG;
            end else if (!held_flag) begin
               phase = PH_FHI;
            end
         end
         PH_LIT: begin
            push_hist(b);
            emit_word(KIND_DATA, {24'h000000, b}, 1, 1'b1);
            pending = pending - 1'b1;
            if (pending == 0)
               phase = PH_CTRL;
         end
         PH_SHORT: begin
            copy_from_hist(b + (held_flag ? 256 : 0), SHORT_BASE - held_num);
            phase = PH_CTRL;
         end
         PH_LONG: begin
            copy_from_hist(b * 2, (LONG_BASE - held_num) * 4 + (held_flag ? LONG_EXTRA : 0));
            phase = PH_CTRL;
         end
         PH_FHI: begin
            fill_high = b;
            phase = PH_FSKIP;
         end
         PH_FSKIP: begin
            phase = PH_FVAL;
         end
         PH_FVAL: begin
            count = clamp_count((LONG_BASE - held_num + 32 * fill_high) * 4);
            for (i = 0; i < count; i++)
               push_hist(b);
            emit_word(KIND_FILL, {24'h000000, b}, count, 1'b1);
            phase = PH_CTRL;
         end
         default: begin
            phase = PH_CTRL;
         end
      endcase
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- driving

   // offer one request and wait for its handshake
   task automatic send_req(input logic [7:0] b, input logic st);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= st;
      do @(posedge clock); while (!req_tready);
      void'(decode_byte(b, st));
      taken_items++;
   endtask

   // wait for every expected word, then let the back part finish any sweep
   task automatic wait_drained();
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_out_length(input logic [23:0] len);
      req_tvalid <= 1'b0;
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      out_len = len;
   endtask

   // copy distance byte, mostly close enough to hit real history
   function automatic logic [7:0] near_dist();
      return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
   endfunction

   // one well-formed command with random content, or a stray byte
   task automatic send_random_command();
      logic [4:0]  num;
      logic        flag;
      logic        st;
      int unsigned pick;
      int unsigned run;
      num  = 5'($urandom_range(0, 31));
      flag = 1'($urandom_range(0, 1));
      st   = ($urandom_range(0, 15) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         // literal run, mostly short
         if ($urandom_range(0, 3) != 0)
            num = 5'($urandom_range(25, 31));
         send_req({CODE_LIT, flag, num}, st);
         for (run = 0; run < 31 - num; run++)
            send_req(8'($urandom), 1'b0);
      end else if (pick < 55) begin
         send_req({CODE_SHORT, flag, num}, st);
         send_req(near_dist(), 1'b0);
      end else if (pick < 75) begin
         send_req({CODE_LONG, flag, num}, st);
         send_req(near_dist(), 1'b0);
      end else if (pick < 88) begin
         // fill, mostly a short run, now and then a huge one
         send_req({CODE_FILL, 1'b0, num}, st);
         send_req(($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1)),
                  1'b0);
         send_req(8'($urandom), 1'b0);
         send_req(8'($urandom), 1'b0);
      end else if (pick < 93) begin
         send_req({CODE_FILL, 1'b1, num}, st);
      end else begin
         // stray byte, sometimes a restart in the middle of a command
         send_req(8'($urandom), ($urandom_range(0, 3) == 0));
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      set_out_length(24'hFFFFFF);
      // three literals, two of them at the byte extremes, opening a new stream
      send_req({CODE_LIT, 1'b0, 5'd28}, 1'b1);
      send_req(8'h00, 1'b0);
      send_req(8'hFF, 1'b0);
      send_req(8'h5A, 1'b0);
      // overlapping short copy repeats the last three bytes
      send_req({CODE_SHORT, 1'b0, 5'd0}, 1'b0);
      send_req(8'd3, 1'b0);
      // farthest short distance, before the output start: zeros
      send_req({CODE_SHORT, 1'b1, 5'd31}, 1'b0);
      send_req(8'hFF, 1'b0);
      // distance zero reads zeros
      send_req({CODE_SHORT, 1'b0, 5'd5}, 1'b0);
      send_req(8'h00, 1'b0);
      // shortest long copy with the two extra bytes
      send_req({CODE_LONG, 1'b1, 5'd31}, 1'b0);
      send_req(8'd1, 1'b0);
      // longest long copy without the extra bytes, at the farthest even distance
      send_req({CODE_LONG, 1'b0, 5'd0}, 1'b0);
      send_req(8'hFF, 1'b0);
      // shortest fill
      send_req({CODE_FILL, 1'b0, 5'd31}, 1'b0);
      send_req(8'h00, 1'b0);
      send_req(8'hAA, 1'b0);
      send_req(8'hFF, 1'b0);
      // longest fill
      send_req({CODE_FILL, 1'b0, 5'd0}, 1'b0);
      send_req(8'hFF, 1'b0);
      send_req(8'h00, 1'b0);
      send_req(8'h3C, 1'b0);
      // no-op marker and an empty literal run
      send_req({CODE_FILL, 1'b1, 5'd31}, 1'b0);
      send_req({CODE_LIT, 1'b1, 5'd31}, 1'b0);
      // single literal, then a copy reaching far back into the fill
      send_req({CODE_LIT, 1'b0, 5'd30}, 1'b0);
      send_req(8'hC3, 1'b0);
      send_req({CODE_SHORT, 1'b1, 5'd0}, 1'b0);
      send_req(8'hFF, 1'b0);
   endtask

   task automatic test_length_limit();
      // zero length ignores everything, restarts included
      set_out_length(24'h000000);
      send_req({CODE_LIT, 1'b0, 5'd29}, 1'b1);
      send_req(8'h11, 1'b0);
      send_req(8'h22, 1'b0);
      // copy clamped at the limit, later input ignored
      set_out_length(24'd10);
      send_req({CODE_LIT, 1'b0, 5'd28}, 1'b1);
      send_req(8'h01, 1'b0);
      send_req(8'h02, 1'b0);
      send_req(8'h03, 1'b0);
      send_req({CODE_SHORT, 1'b0, 5'd0}, 1'b0);
      send_req(8'd1, 1'b0);
      send_req({CODE_LIT, 1'b0, 5'd30}, 1'b0);
      send_req(8'h44, 1'b0);
      // restart, long copy of zeros clamped at the limit
      send_req({CODE_LONG, 1'b1, 5'd0}, 1'b1);
      send_req(8'd1, 1'b0);
      // limit lowered below what was produced: ignored until a restart
      set_out_length(24'd5);
      send_req({CODE_LIT, 1'b0, 5'd30}, 1'b0);
      send_req(8'h55, 1'b0);
      send_req({CODE_FILL, 1'b0, 5'd31}, 1'b1);
      send_req(8'h00, 1'b0);
      send_req(8'h00, 1'b0);
      send_req(8'h77, 1'b0);
      send_req({CODE_LIT, 1'b0, 5'd29}, 1'b0);
      send_req(8'h88, 1'b0);
      send_req(8'h99, 1'b0);
   endtask

   task automatic test_random_traffic(input logic [23:0] len, input int unsigned n);
      int unsigned target;
      set_out_length(len);
      target = taken_items + n;
      while (taken_items < target)
         send_random_command();
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      int unsigned target;
      set_out_length(24'hFFFFFF);
      hold_off_req++;
      target = taken_items + 40;
      while (taken_items < target)
         send_random_command();
   endtask

   task automatic test_no_idle();
      set_out_length(24'($urandom_range(300, 4000)));
      gaps_on = 1'b0;
      test_random_traffic(out_len, 60);
   endtask

   initial begin : test_sequence
      hist      = '{default: 8'h00};
      wr_pos    = '0;
      produced  = '0;
      out_len   = '0;
      phase     = PH_CTRL;
      pending   = '0;
      held_num  = '0;
      held_flag = 1'b0;
      fill_high = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_length_limit();
      test_random_traffic(24'hFFFFFF, 120);
      test_random_traffic(24'($urandom_range(64, 2000)), 80);
      test_backpressure();
      test_no_idle();
      req_tvalid <= 1'b0;
      wait_drained();
      if (fail_count == 0)
         $display("[lz_byte_stream_decompressor_top] OK");
      else
         $display("[lz_byte_stream_decompressor_top] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- result side

   // ready with random stall bursts and the long hold-off
   always @(posedge clock) begin
      if (hold_off_seen != hold_off_req) begin
         hold_off_seen = hold_off_req;
         stall_left = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 16);
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: data %0h length %0h", rsp_tdata[31:0], rsp_tdata[47:32]);
            fail_count++;
         end else begin
            check_head = expected_words.pop_front();
            check_field("kind", 32'(check_head.kind), 32'(rsp_tuser));
            check_field("data", check_head.data, rsp_tdata[31:0]);
            check_field("length", 32'(check_head.length), 32'(rsp_tdata[47:32]));
            check_field("last_of_run", 32'(check_head.last), 32'(rsp_tlast));
            check_field("done_res", 32'(check_head.done), 32'(rsp_tdata[48]));
         end
      end
   end

   // end the run when neither side has moved for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[lz_byte_stream_decompressor_top] ERROR");
         $finish;
      end
   end

endmodule
